// ----- hw/rtl/icdf_pkg.sv -----
// Shared constants and types for the inverse-CDF sampler.
// No dependencies; used by icdf_datapath, icdf_ctrl and inverse_cdf_sampler_unit.
package icdf_pkg;

  localparam int MAX_BINS = 1024;
  localparam int IDX_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int WGT_W    = 16;
  localparam int U_W      = 16;
  localparam int SUM_W    = WGT_W + IDX_W;
  localparam int PROD_W   = SUM_W + U_W;
  localparam int BIN_W    = 10;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic issue;
    logic step;
    logic out_load;
  } icdf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic lo_eq_hi;
    logic step_done;
  } icdf_status_t;

endpackage

// ----- hw/rtl/inverse_cdf_sampler_unit.sv -----
// Weighted sampler, top level: ties the controller to the datapath.
// Depends on icdf_pkg, icdf_datapath, icdf_ctrl.
//
// Usage: one input channel (in_valid/in_ready) carries a beat of cmd,
// weight and uniform. cmd CLEAR empties the table, APPEND stores the
// running prefix sum (dropped once 1024 bins are held), QUERY returns one
// beat on the output channel (out_valid/out_ready): the smallest bin whose
// prefix sum * 65536 reaches uniform * total, or empty_error=1 with bin 0
// when the total weight is zero. Unused cmd code 3 is consumed silently.
// CLEAR and APPEND beats are accepted back to back.
// A QUERY holds in_ready low through the probe state, the compare state
// (bisection steps, each on one table read, until the bounds meet) and the
// result state; an empty or zero-total table goes straight to the result
// state, and a single bin skips the compare state. The search is paced by
// the one-read table memory, probed once per cycle by the bisection loop.
// The result sits in an output register; the next beat is taken while it
// waits. If the receiver stalls, a second query finishes its search and
// then holds until the output register frees.
// Reset: bin count and total go to zero; the table memory is not cleared,
// since entries past the bin count are never read.
module inverse_cdf_sampler_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [icdf_pkg::WGT_W-1:0]   weight,
  input  logic [icdf_pkg::U_W-1:0]     uniform,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [icdf_pkg::BIN_W-1:0]   bin,
  output logic                         empty_error
);

  icdf_pkg::icdf_cmd_t    ctl;
  icdf_pkg::icdf_status_t st;

  icdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  icdf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .weight      (weight),
    .uniform     (uniform),
    .st          (st),
    .bin         (bin),
    .empty_error (empty_error)
  );

`ifndef ASSERT_OFF
  // an error result always reports bin 0
  a_err_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_error |-> bin == '0)
    else $error("error result with nonzero bin");

  // a clear leaves the table empty
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == icdf_pkg::CMD_CLEAR |=> st.empty)
    else $error("table not empty after clear");

  // an accepted query always takes the block out of idle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == icdf_pkg::CMD_QUERY |=> !in_ready)
    else $error("input accepted during query");

  // no search step while the input side is open
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ctl.step && !ctl.issue && !ctl.out_load)
    else $error("search activity while idle");
`endif

endmodule

// ----- hw/rtl/icdf_datapath.sv -----
// Datapath: prefix-sum memory, running total, bin count and bisection registers.
// Depends on icdf_pkg.
module icdf_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  icdf_pkg::icdf_cmd_t          ctl,
  input  logic [icdf_pkg::WGT_W-1:0]   weight,
  input  logic [icdf_pkg::U_W-1:0]     uniform,
  output icdf_pkg::icdf_status_t       st,
  output logic [icdf_pkg::BIN_W-1:0]   bin,
  output logic                         empty_error
);

  logic [icdf_pkg::SUM_W-1:0]  mem [icdf_pkg::MAX_BINS];
  logic [icdf_pkg::SUM_W-1:0]  rd_data;
  logic [icdf_pkg::CNT_W-1:0]  count;
  logic [icdf_pkg::SUM_W-1:0]  total;
  logic [icdf_pkg::SUM_W-1:0]  total_next;
  logic [icdf_pkg::IDX_W-1:0]  lo, hi, mid;
  logic [icdf_pkg::IDX_W-1:0]  lo_next, hi_next, mid_next;
  logic [icdf_pkg::PROD_W-1:0] goal;
  logic                        err_q;
  logic                        ge;
  logic                        full;

  assign total_next = total + icdf_pkg::SUM_W'(weight);
  assign full       = (count == icdf_pkg::CNT_W'(icdf_pkg::MAX_BINS));
  assign ge         = ({rd_data, {icdf_pkg::U_W{1'b0}}} >= goal);

  // bisection step; on issue the current bounds feed the address
  always_comb begin
    if (ctl.step) begin
      lo_next = ge ? lo : mid + icdf_pkg::IDX_W'(1);
      hi_next = ge ? mid : hi;
    end else begin
      lo_next = lo;
      hi_next = hi;
    end
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
  end

  assign st.empty     = (total == '0);
  assign st.lo_eq_hi  = (lo == hi);
  assign st.step_done = (lo_next >= hi_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (ctl.clear) begin
      count <= '0;
      total <= '0;
    end else if (ctl.append && !full) begin
      count <= count + icdf_pkg::CNT_W'(1);
      total <= total_next;
    end
  end

  // table: written on append, read once per probe
  always_ff @(posedge clk) begin
    if (ctl.append && !full) begin
      mem[count[icdf_pkg::IDX_W-1:0]] <= total_next;
    end
    if (ctl.issue || ctl.step) begin
      rd_data <= mem[mid_next];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lo    <= '0;
      hi    <= icdf_pkg::IDX_W'(count - icdf_pkg::CNT_W'(1));
      goal  <= icdf_pkg::PROD_W'(uniform) * icdf_pkg::PROD_W'(total);
      err_q <= st.empty;
    end else begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (ctl.issue || ctl.step) begin
      mid <= mid_next;
    end
    if (ctl.out_load) begin
      bin         <= err_q ? '0 : icdf_pkg::BIN_W'(lo);
      empty_error <= err_q;
    end
  end

endmodule

// ----- hw/rtl/icdf_ctrl.sv -----
// Controller: command decode and bisection sequencing, output valid.
// Depends on icdf_pkg; drives icdf_datapath.
module icdf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  icdf_pkg::icdf_status_t st,
  output icdf_pkg::icdf_cmd_t    ctl
);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CMP, S_RESULT} state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.clear  = (cmd == icdf_pkg::CMD_CLEAR);
          ctl.append = (cmd == icdf_pkg::CMD_APPEND);
          ctl.load   = (cmd == icdf_pkg::CMD_QUERY);
        end
      end
      S_PROBE:  ctl.issue = !st.lo_eq_hi;
      S_CMP:    ctl.step = 1'b1;
      S_RESULT: ctl.out_load = out_free;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result beat takes priority over the one leaving
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && cmd == icdf_pkg::CMD_QUERY) begin
            state <= st.empty ? S_RESULT : S_PROBE;
          end
        end
        S_PROBE: state <= st.lo_eq_hi ? S_RESULT : S_CMP;
        S_CMP: begin
          if (st.step_done) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
